// ----- hdl/at_response_line_classifier_defines.svh -----
// Assertion macros used by the line classifier top level.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define ATRLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("at_rlc: same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define ATRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("at_rlc: next-cycle check failed");

`endif

// ----- hdl/at_rlc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package at_rlc_pkg;

  // Number of sockets a pending-bytes notice may name (1 to 8).
  localparam int unsigned SOCKET_COUNT = 8;

  localparam int unsigned PAT_COUNT = 8;
  localparam int unsigned PAT_MAX_LEN = 11;
  localparam int unsigned POS_W = 4;
  localparam int unsigned ACC_W = 16;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [ACC_W-1:0] acc_t;

  // Pattern text, first character in slot 0, zero padded.
  localparam logic [0:PAT_MAX_LEN-1][7:0] PAT_AT      = {"AT", 72'h0};
  localparam logic [0:PAT_MAX_LEN-1][7:0] PAT_OK      = {"OK", 72'h0};
  localparam logic [0:PAT_MAX_LEN-1][7:0] PAT_ERROR   = {"ERROR", 48'h0};
  localparam logic [0:PAT_MAX_LEN-1][7:0] PAT_CME     = "+CME ERROR:";
  localparam logic [0:PAT_MAX_LEN-1][7:0] PAT_CMS     = "+CMS ERROR:";
  localparam logic [0:PAT_MAX_LEN-1][7:0] PAT_AT_SIGN = {"@", 80'h0};
  localparam logic [0:PAT_MAX_LEN-1][7:0] PAT_GT      = {">", 80'h0};
  localparam logic [0:PAT_MAX_LEN-1][7:0] PAT_NOTICE  = {"+UUSORD:", 24'h0};

  localparam logic [PAT_COUNT-1:0][0:PAT_MAX_LEN-1][7:0] PAT_TEXT = {
    PAT_NOTICE, PAT_GT, PAT_AT_SIGN, PAT_CMS, PAT_CME, PAT_ERROR, PAT_OK, PAT_AT
  };
  localparam logic [PAT_COUNT-1:0][POS_W-1:0] PAT_LEN = {
    4'd8, 4'd1, 4'd1, 4'd11, 4'd11, 4'd5, 4'd2, 4'd2
  };

  localparam logic [2:0] PAT_IDX_AT      = 3'd0;
  localparam logic [2:0] PAT_IDX_OK      = 3'd1;
  localparam logic [2:0] PAT_IDX_ERROR   = 3'd2;
  localparam logic [2:0] PAT_IDX_CME     = 3'd3;
  localparam logic [2:0] PAT_IDX_CMS     = 3'd4;
  localparam logic [2:0] PAT_IDX_AT_SIGN = 3'd5;
  localparam logic [2:0] PAT_IDX_GT      = 3'd6;
  localparam logic [2:0] PAT_IDX_NOTICE  = 3'd7;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [2:0] {
    CLS_ECHO   = 3'd0,
    CLS_OK     = 3'd1,
    CLS_ERROR  = 3'd2,
    CLS_PROMPT = 3'd3,
    CLS_OTHER  = 3'd4
  } line_class_e;

  // One accepted character beat.
  typedef struct packed {
    logic       accept;
    logic [7:0] char_code;
    logic       eol;
  } beat_t;

  // Line class for the line that ends on this beat.
  typedef struct packed {
    logic        nonempty;
    line_class_e cls;
  } line_res_t;

  // Notice fields for the line that ends on this beat.
  typedef struct packed {
    logic       valid;
    logic [2:0] socket;
    acc_t       pending;
  } notice_res_t;

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Character at position pos of pattern k differs from c (only within its length).
  function automatic logic pat_miss(input logic [2:0] k, input pos_t pos,
                                    input logic [7:0] c);
    logic       in_len;
    logic [3:0] idx;
    in_len = pos < PAT_LEN[k];
    idx    = in_len ? pos : 4'd0;
    return in_len && (PAT_TEXT[k][idx] != c);
  endfunction

  // acc * 10 + d, saturating at the accumulator maximum.
  function automatic acc_t add_digit(input acc_t acc, input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{ACC_W{1'b0}}, d};
    return (v > {4'd0, {ACC_W{1'b1}}}) ? {ACC_W{1'b1}} : v[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/at_response_line_classifier.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "at_response_line_classifier_defines.svh"

// Channel   Handshake              Payload
// -------   --------------------   -----------------------------------------------
// input     in_valid_i/in_ready_o  char_code_i[7:0], end_of_line_i
// output    out_valid_o/out_ready_i line_class_o[2:0], notice_valid_o,
//                                   notice_socket_o[2:0], notice_pending_o[15:0]
//
// One character beat is taken per cycle while in_ready_o is high; a non-empty line's
// result appears in the output register in the cycle after the beat that carries end_of_line.
// The per-line state (prefix flags, notice parser, accumulators) updates on the
// accepting edge, so the next beat can follow directly.
// Reset (rst_ni low) clears the line state and empties the output register.
// A result waiting in the output register stalls the input only when the sink
// holds out_ready_i low; the input is ready again in the cycle the result leaves.
// CR and LF beats carry no character but still end a line when flagged.
module at_response_line_classifier import at_rlc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_line_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [2:0]  line_class_o,
  output      logic        notice_valid_o,
  output      logic [2:0]  notice_socket_o,
  output      logic [15:0] notice_pending_o
);

  beat_t       beat;
  pos_t        pos;
  line_res_t   line_res;
  notice_res_t notice_res;
  logic        emit;

  logic        out_valid_q, out_valid_d;
  line_class_e cls_q;
  notice_res_t notice_q;

  // Take a beat whenever the output slot is free or is being drained.
  assign in_ready_o     = !out_valid_q || out_ready_i;
  assign beat.accept    = in_valid_i && in_ready_o;
  assign beat.char_code = char_code_i;
  assign beat.eol       = end_of_line_i;

  at_rlc_line_match u_line_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .pos_o  (pos),
    .res_o  (line_res)
  );

  at_rlc_notice_parser u_notice_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .pos_i  (pos),
    .res_o  (notice_res)
  );

  // A line yields a result only if it held at least one kept character.
  assign emit = beat.accept && beat.eol && line_res.nonempty;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload until the next line result loads.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      cls_q    <= line_res.cls;
      notice_q <= notice_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign line_class_o     = cls_q;
  assign notice_valid_o   = notice_q.valid;
  assign notice_socket_o  = notice_q.socket;
  assign notice_pending_o = notice_q.pending;

  `ATRLC_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, emit, out_valid_o)
  `ATRLC_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  `ATRLC_ASSERT_NOW(a_notice_zero, clk_i, rst_ni, out_valid_o && !notice_valid_o,
                    (notice_socket_o == 3'd0) && (notice_pending_o == 16'd0))
  `ATRLC_ASSERT_NOW(a_class_range, clk_i, rst_ni, out_valid_o,
                    line_class_o <= CLS_OTHER)
  `ATRLC_ASSERT_NEXT(a_no_phantom, clk_i, rst_ni, !emit && (!out_valid_o || out_ready_i),
                     !out_valid_o)

endmodule

`default_nettype wire

// ----- hdl/at_rlc_line_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Prefix tracking for the reply patterns and line classification.
module at_rlc_line_match import at_rlc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire beat_t     beat_i,
  output      pos_t      pos_o,
  output      line_res_t res_o
);

  localparam int unsigned LINE_PATS = PAT_COUNT - 1;

  pos_t                 pos_q, pos_d;
  logic [LINE_PATS-1:0] alive_q, alive_d;
  logic                 nonempty_q, nonempty_d;
  logic [LINE_PATS-1:0] hit;
  line_class_e          cls;

  always_comb begin
    pos_d      = pos_q;
    alive_d    = alive_q;
    nonempty_d = nonempty_q;
    if (!is_term(beat_i.char_code)) begin
      for (int k = 0; k < LINE_PATS; k++) begin
        if (pat_miss(3'(k), pos_q, beat_i.char_code)) begin
          alive_d[k] = 1'b0;
        end
      end
      nonempty_d = 1'b1;
      if (pos_q != {POS_W{1'b1}}) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < LINE_PATS; k++) begin
      hit[k] = alive_d[k] && (pos_d >= PAT_LEN[k]);
    end
    priority if (hit[PAT_IDX_AT]) begin
      cls = CLS_ECHO;
    end else if (hit[PAT_IDX_OK]) begin
      cls = CLS_OK;
    end else if (hit[PAT_IDX_ERROR] || hit[PAT_IDX_CME] || hit[PAT_IDX_CMS]) begin
      cls = CLS_ERROR;
    end else if (hit[PAT_IDX_AT_SIGN] || hit[PAT_IDX_GT]) begin
      cls = CLS_PROMPT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign res_o.nonempty = nonempty_d;
  assign res_o.cls      = cls;
  assign pos_o          = pos_q;

  // Advance on every accepted beat, restart the line after its end-of-line beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      alive_q    <= '1;
      nonempty_q <= 1'b0;
    end else if (beat_i.accept) begin
      if (beat_i.eol) begin
        pos_q      <= '0;
        alive_q    <= '1;
        nonempty_q <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        alive_q    <= alive_d;
        nonempty_q <= nonempty_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/at_rlc_notice_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Parser for the "+UUSORD: socket,count" pending-bytes notice.
module at_rlc_notice_parser import at_rlc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire beat_t       beat_i,
  input  wire pos_t        pos_i,
  output      notice_res_t res_o
);

  typedef enum logic [7:0] {
    PH_LITERAL   = 8'b0000_0001,
    PH_SOCK_PRE  = 8'b0000_0010,
    PH_SOCK_SIGN = 8'b0000_0100,
    PH_SOCK_DIG  = 8'b0000_1000,
    PH_CNT_PRE   = 8'b0001_0000,
    PH_CNT_SIGN  = 8'b0010_0000,
    PH_CNT_DIG   = 8'b0100_0000,
    PH_DONE      = 8'b1000_0000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       alive_q, alive_d;
  acc_t       sock_q, sock_d;
  acc_t       cnt_q, cnt_d;
  logic [7:0] c;
  logic       digit;
  logic [3:0] dval;
  logic       valid;

  assign c     = beat_i.char_code;
  assign digit = is_digit(c);
  assign dval  = digit ? 4'(c - CH_ZERO) : 4'd0;

  always_comb begin
    phase_d = phase_q;
    alive_d = alive_q;
    sock_d  = sock_q;
    cnt_d   = cnt_q;
    if (!is_term(c)) begin
      if (pat_miss(PAT_IDX_NOTICE, pos_i, c)) begin
        alive_d = 1'b0;
      end
      unique case (phase_q)
        PH_LITERAL: begin
          if (!alive_d) begin
            phase_d = PH_DONE;
          end else if (pos_i == PAT_LEN[PAT_IDX_NOTICE] - 1'b1) begin
            phase_d = PH_SOCK_PRE;
          end
        end
        PH_SOCK_PRE, PH_CNT_PRE: begin
          if (is_blank(c)) begin
            phase_d = phase_q;
          end else if (c == CH_PLUS) begin
            phase_d = (phase_q == PH_SOCK_PRE) ? PH_SOCK_SIGN : PH_CNT_SIGN;
          end else if (digit) begin
            if (phase_q == PH_SOCK_PRE) begin
              sock_d  = ACC_W'(dval);
              phase_d = PH_SOCK_DIG;
            end else begin
              cnt_d   = ACC_W'(dval);
              phase_d = PH_CNT_DIG;
            end
          end else begin
            alive_d = 1'b0;
            phase_d = PH_DONE;
          end
        end
        PH_SOCK_SIGN, PH_CNT_SIGN: begin
          if (!digit) begin
            alive_d = 1'b0;
            phase_d = PH_DONE;
          end else if (phase_q == PH_SOCK_SIGN) begin
            sock_d  = ACC_W'(dval);
            phase_d = PH_SOCK_DIG;
          end else begin
            cnt_d   = ACC_W'(dval);
            phase_d = PH_CNT_DIG;
          end
        end
        PH_SOCK_DIG: begin
          if (digit) begin
            sock_d = add_digit(sock_q, dval);
          end else if (c == CH_COMMA) begin
            phase_d = PH_CNT_PRE;
          end else begin
            alive_d = 1'b0;
            phase_d = PH_DONE;
          end
        end
        PH_CNT_DIG: begin
          if (digit) begin
            cnt_d = add_digit(cnt_q, dval);
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  assign valid = alive_d && ((phase_d == PH_CNT_DIG) || (phase_d == PH_DONE))
              && (sock_d < ACC_W'(SOCKET_COUNT));

  assign res_o.valid   = valid;
  assign res_o.socket  = valid ? sock_d[2:0] : 3'd0;
  assign res_o.pending = valid ? cnt_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LITERAL;
      alive_q <= 1'b1;
      sock_q  <= '0;
      cnt_q   <= '0;
    end else if (beat_i.accept) begin
      if (beat_i.eol) begin
        phase_q <= PH_LITERAL;
        alive_q <= 1'b1;
        sock_q  <= '0;
        cnt_q   <= '0;
      end else begin
        phase_q <= phase_d;
        alive_q <= alive_d;
        sock_q  <= sock_d;
        cnt_q   <= cnt_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_at_response_line_classifier.sv -----
`timescale 1ns / 1ps

module tb_at_response_line_classifier;
  import at_rlc_pkg::*;

  // Give up when no beat moves on either channel for this many cycles. The
  // longest legal quiet stretch is the forced sink hold of HOLD_CYCLES.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 60;

  // Pattern slots, in the order the prefix flags are kept.
  localparam int PAT_ECHO = 0;
  localparam int PAT_OK = 1;
  localparam int PAT_ERR = 2;
  localparam int PAT_CME = 3;
  localparam int PAT_CMS = 4;
  localparam int PAT_AT_SIGN = 5;
  localparam int PAT_GT = 6;
  localparam int PAT_NOTICE = 7;
  localparam int PAT_LAST_CLASS = 6;
  // Position of the colon that closes the notice literal.
  localparam logic [3:0] NOTICE_COLON_POS = 4'd7;
  localparam logic [3:0] POS_MAX = 4'd15;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [2:0] {
    PH_LITERAL      = 3'd0,
    PH_SOCK_LEAD    = 3'd1,
    PH_SOCK_SIGN    = 3'd2,
    PH_SOCK_DIGITS  = 3'd3,
    PH_COUNT_LEAD   = 3'd4,
    PH_COUNT_SIGN   = 3'd5,
    PH_COUNT_DIGITS = 3'd6,
    PH_DONE         = 3'd7
  } notice_phase_e;

  typedef enum int {
    END_ON_CHAR,
    END_CRLF,
    END_ON_CR
  } line_end_e;

  typedef struct packed {
    line_class_e cls;
    logic        nv;
    logic [2:0]  socket;
    logic [15:0] pending;
  } line_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] char_code = 8'd0;
  logic eol_flag = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] line_class;
  logic notice_valid;
  logic [2:0] notice_socket;
  logic [15:0] notice_pending;

  // Line state of the predictor.
  logic [3:0] line_pos;
  logic [7:0] prefix_live;
  notice_phase_e phase;
  logic [15:0] socket_acc;
  logic [15:0] count_acc;
  logic line_seen;

  line_result_t expected_lines[$];
  logic [7:0] line_chars[$];
  int mismatch_count = 0;
  int kept_chars = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  at_response_line_classifier u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .char_code_i     (char_code),
    .end_of_line_i   (eol_flag),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .line_class_o    (line_class),
    .notice_valid_o  (notice_valid),
    .notice_socket_o (notice_socket),
    .notice_pending_o(notice_pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line predictor
  // ---------------------------------------------------------------------------

  function automatic string pattern_text(input int k);
    case (k)
      PAT_ECHO:    return "AT";
      PAT_OK:      return "OK";
      PAT_ERR:     return "ERROR";
      PAT_CME:     return "+CME ERROR:";
      PAT_CMS:     return "+CMS ERROR:";
      PAT_AT_SIGN: return "@";
      PAT_GT:      return ">";
      default:     return "+UUSORD:";
    endcase
  endfunction

  function automatic void clear_line();
    line_pos = 4'd0;
    prefix_live = 8'hFF;
    phase = PH_LITERAL;
    socket_acc = 16'd0;
    count_acc = 16'd0;
    line_seen = 1'b0;
  endfunction

  // acc * 10 + d, clamped to 16 bits
  function automatic logic [15:0] decimal_push(input logic [15:0] acc, input logic [3:0] d);
    logic [31:0] wide;
    wide = 32'(acc) * 10 + 32'(d);
    return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
  endfunction

  function automatic logic pattern_hit(input int k);
    string p;
    p = pattern_text(k);
    return prefix_live[k] && (int'(line_pos) >= p.len());
  endfunction

  function automatic void notice_abort();
    prefix_live[PAT_NOTICE] = 1'b0;
    phase = PH_DONE;
  endfunction

  // Advance the "+UUSORD: socket,count" parser by one kept character.
  function automatic void notice_step(input logic [7:0] c, input logic [3:0] pos);
    logic is_dig;
    logic is_blank;
    logic [7:0] diff;
    logic [3:0] d;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    diff = c - CH_ZERO;
    d = is_dig ? diff[3:0] : 4'd0;
    case (phase)
      PH_LITERAL: begin
        if (!prefix_live[PAT_NOTICE]) phase = PH_DONE;
        else if (pos == NOTICE_COLON_POS) phase = PH_SOCK_LEAD;
      end
      PH_SOCK_LEAD, PH_COUNT_LEAD: begin
        if (!is_blank) begin
          if (c == CH_PLUS) begin
            phase = (phase == PH_SOCK_LEAD) ? PH_SOCK_SIGN : PH_COUNT_SIGN;
          end else if (is_dig) begin
            if (phase == PH_SOCK_LEAD) begin
              socket_acc = 16'(d);
              phase = PH_SOCK_DIGITS;
            end else begin
              count_acc = 16'(d);
              phase = PH_COUNT_DIGITS;
            end
          end else begin
            notice_abort();
          end
        end
      end
      PH_SOCK_SIGN, PH_COUNT_SIGN: begin
        if (!is_dig) begin
          notice_abort();
        end else if (phase == PH_SOCK_SIGN) begin
          socket_acc = 16'(d);
          phase = PH_SOCK_DIGITS;
        end else begin
          count_acc = 16'(d);
          phase = PH_COUNT_DIGITS;
        end
      end
      PH_SOCK_DIGITS: begin
        if (is_dig) socket_acc = decimal_push(socket_acc, d);
        else if (c == CH_COMMA) phase = PH_COUNT_LEAD;
        else notice_abort();
      end
      PH_COUNT_DIGITS: begin
        if (is_dig) count_acc = decimal_push(count_acc, d);
        else phase = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  // Apply one accepted beat; queue the line result when a non-empty line ends.
  function automatic void classify_char(input logic [7:0] c, input logic eol);
    string p;
    line_result_t r;
    if (c != CH_LF && c != CH_CR) begin
      for (int k = 0; k <= PAT_NOTICE; k++) begin
        p = pattern_text(k);
        if (int'(line_pos) < p.len() && p[line_pos] != c) prefix_live[k] = 1'b0;
      end
      line_seen = 1'b1;
      notice_step(c, line_pos);
      if (line_pos != POS_MAX) line_pos = line_pos + 4'd1;
    end
    if (eol) begin
      if (line_seen) begin
        if (pattern_hit(PAT_ECHO)) r.cls = CLS_ECHO;
        else if (pattern_hit(PAT_OK)) r.cls = CLS_OK;
        else if (pattern_hit(PAT_ERR) || pattern_hit(PAT_CME) || pattern_hit(PAT_CMS))
          r.cls = CLS_ERROR;
        else if (pattern_hit(PAT_AT_SIGN) || pattern_hit(PAT_GT)) r.cls = CLS_PROMPT;
        else r.cls = CLS_OTHER;
        r.nv = prefix_live[PAT_NOTICE] && (phase == PH_COUNT_DIGITS || phase == PH_DONE)
               && (32'(socket_acc) < SOCKET_COUNT);
        r.socket = r.nv ? socket_acc[2:0] : 3'd0;
        r.pending = r.nv ? count_acc : 16'd0;
        expected_lines.push_back(r);
      end
      clear_line();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sink side: random ready, with a forced hold when hold_left is set
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare each result beat with the oldest queued line result.
  always @(posedge clk) begin : check_results
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual class %0d notice %0d",
                   $time, line_class, notice_valid);
      end else begin
        want = expected_lines.pop_front();
        check_field("line_class", 16'(want.cls), 16'(line_class));
        check_field("notice_valid", 16'(want.nv), 16'(notice_valid));
        check_field("notice_socket", 16'(want.socket), 16'(notice_socket));
        check_field("notice_pending", want.pending, notice_pending);
      end
    end
  end

  // Watchdog: count cycles in which no beat moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                   $time, quiet_cycles, expected_lines.size());
          $display("** at_response_line_classifier: FAILED **");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Offer one beat, idle first at random, and hold it until accepted.
  task automatic send_beat(input logic [7:0] c, input logic eol);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    char_code = c;
    eol_flag = eol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    classify_char(c, eol);
    if (c != CH_LF && c != CH_CR) kept_chars++;
  endtask

  function automatic void put_byte(input logic [7:0] b);
    line_chars.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endfunction

  // Send line_chars, then close the line the requested way.
  task automatic send_line(input line_end_e ending);
    int n;
    n = line_chars.size();
    if (n == 0 && ending == END_ON_CHAR) begin
      send_beat(CH_LF, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++)
      send_beat(line_chars[i], (ending == END_ON_CHAR) && (i == n - 1));
    case (ending)
      END_CRLF: begin
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b1);
      end
      END_ON_CR: send_beat(CH_CR, 1'b1);
      default: ;
    endcase
  endtask

  task automatic say_line(input string s, input line_end_e ending);
    line_chars.delete();
    put_text(s);
    send_line(ending);
  endtask

  // ---------------------------------------------------------------------------
  // Random line builders
  // ---------------------------------------------------------------------------

  // Mostly small values, some near and past saturation, some zero padded.
  function automatic string rand_number(input int unsigned small_max);
    int unsigned v;
    string s;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom_range(small_max);
      5, 6: v = $urandom_range(65535);
      7: v = 65525 + $urandom_range(20);
      default: v = $urandom;
    endcase
    s = $sformatf("%0d", v);
    if ($urandom_range(7) == 0) s = {"00", s};
    return s;
  endfunction

  function automatic void put_blanks();
    if ($urandom_range(1) != 0) begin
      repeat ($urandom_range(2, 1)) begin
        case ($urandom_range(3))
          0: put_byte(CH_SPACE);
          1: put_byte(CH_TAB);
          2: put_byte(CH_VT);
          default: put_byte(CH_FF);
        endcase
      end
    end
  endfunction

  function automatic void put_sign();
    int r;
    r = $urandom_range(19);
    if (r < 4) put_byte(CH_PLUS);
    else if (r == 4) put_byte(CHAR_MINUS);
  endfunction

  function automatic void put_tail(input int max_len);
    repeat ($urandom_range(max_len)) begin
      if ($urandom_range(1) != 0) put_byte(8'($urandom_range(126, 32)));
      else put_byte(8'($urandom_range(255)));
    end
  endfunction

  function automatic void build_notice();
    put_text("+UUSORD:");
    put_blanks();
    put_sign();
    put_text(rand_number(SOCKET_COUNT));
    // a blank between socket digits and comma spoils the notice
    if ($urandom_range(11) == 0) put_byte(CH_SPACE);
    put_byte(CH_COMMA);
    put_blanks();
    put_sign();
    put_text(rand_number(300));
    if ($urandom_range(3) == 0) put_tail(3);
  endfunction

  // Break a well-formed line: overwrite, truncate or insert a minus sign.
  function automatic void corrupt_line();
    int idx;
    if (line_chars.size() == 0) return;
    idx = $urandom_range(line_chars.size() - 1);
    case ($urandom_range(2))
      0: line_chars[idx] = 8'($urandom_range(255));
      1: while (line_chars.size() > idx) void'(line_chars.pop_back());
      default: line_chars.insert(idx, CHAR_MINUS);
    endcase
  endfunction

  function automatic void build_random_line();
    int roll;
    line_chars.delete();
    roll = $urandom_range(99);
    if (roll < 40) begin
      build_notice();
    end else if (roll < 75) begin
      put_text(pattern_text($urandom_range(PAT_LAST_CLASS)));
      put_tail(4);
    end else if (roll < 93) begin
      repeat ($urandom_range(18, 1)) put_byte(8'($urandom_range(255)));
    end
    if (roll < 75 && $urandom_range(99) < 20) corrupt_line();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every line class, prefix boundaries and the terminator handling.
  task automatic test_line_classes();
    say_line("AT", END_ON_CHAR);
    say_line("ATE0", END_CRLF);
    say_line("OK", END_CRLF);
    say_line("ERROR", END_ON_CR);
    say_line("+CME ERROR: 10", END_CRLF);
    say_line("+CMS ERROR:", END_ON_CHAR);
    say_line("+CMS ERROR", END_ON_CHAR);
    say_line("@", END_ON_CHAR);
    say_line("> ", END_CRLF);
    say_line("A", END_ON_CHAR);
    // lines of terminators only end silently
    say_line("", END_CRLF);
    say_line("", END_ON_CR);
    say_line("", END_ON_CHAR);
    // CR in mid line is dropped, so this still reads as OK
    line_chars.delete();
    put_text("O");
    put_byte(CH_CR);
    put_text("K");
    send_line(END_ON_CHAR);
    // NUL and 0xFF are ordinary characters
    line_chars.delete();
    put_byte(8'h00);
    put_byte(8'hFF);
    send_line(END_ON_CHAR);
    // past position 15 the position counter stops
    say_line("+CME ERROR: 1234567890123", END_CRLF);
  endtask

  // Pending-bytes notice: layout, signs, blanks, saturation and socket range.
  task automatic test_notice_parsing();
    say_line("+UUSORD: 3,100", END_CRLF);
    say_line("+UUSORD:0,0", END_ON_CHAR);
    say_line("+UUSORD:+2,+7", END_ON_CR);
    line_chars.delete();
    put_text("+UUSORD:");
    put_byte(CH_SPACE);
    put_byte(CH_TAB);
    put_byte(CH_VT);
    put_byte(CH_FF);
    put_text("7,");
    put_byte(CH_TAB);
    put_text("65536");
    send_line(END_CRLF);
    say_line("+UUSORD: 1,9999999999", END_ON_CHAR);
    say_line("+UUSORD: 8,1", END_ON_CHAR);
    say_line("+UUSORD: 99999,1", END_ON_CHAR);
    say_line("+UUSORD: -1,5", END_ON_CHAR);
    say_line("+UUSORD: 2,-5", END_ON_CHAR);
    say_line("+UUSORD: 1 ,5", END_ON_CHAR);
    say_line("+UUSORD: 1,5xyz", END_CRLF);
    say_line("+UUSORD: 1,", END_ON_CHAR);
    say_line("+UUSORD:", END_ON_CHAR);
    say_line("+UUSORD; 1,5", END_ON_CHAR);
    say_line("+UUSORD: +,5", END_ON_CHAR);
  endtask

  // Random lines until about `target` kept characters have been accepted.
  task automatic test_random_lines(input int target);
    int start;
    start = kept_chars;
    while (kept_chars - start < target) begin
      build_random_line();
      send_line(line_end_e'($urandom_range(2)));
    end
  endtask

  // Hold the sink off while short lines keep coming, so the result register
  // fills and the input stalls.
  task automatic test_sink_backpressure();
    hold_left = HOLD_CYCLES;
    repeat (30) begin
      line_chars.delete();
      put_text(pattern_text($urandom_range(PAT_LAST_CLASS)));
      send_line(END_ON_CHAR);
    end
  endtask

  initial begin
    clear_line();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 28;
    rx_idle_pct = 60;
    test_line_classes();
    test_notice_parsing();
    test_random_lines(30);

    tx_idle_pct = 60;
    rx_idle_pct = 28;
    test_random_lines(30);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_lines(25);
    test_sink_backpressure();

    // drop valid once the last beat is in, then drain
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** at_response_line_classifier: PASSED **");
    end else begin
      $display("** at_response_line_classifier: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/at_rlc_pkg.sv
hdl/at_rlc_line_match.sv
hdl/at_rlc_notice_parser.sv
hdl/at_response_line_classifier.sv
test/tb_at_response_line_classifier.sv
